// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define NRMC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/nrmc_pkg.sv =====
// Package for the RMC time and date parser: phase codes, character constants,
// the sentence capture type and the calendar helper functions. No dependencies.
package nrmc_pkg;

   // Parser phase codes
   localparam logic [3:0] PH_HUNT       = 4'd0;
   localparam logic [3:0] PH_TIME_FIRST = 4'd1;
   localparam logic [3:0] PH_TIME_LAST  = 4'd6;
   localparam logic [3:0] PH_SKIP       = 4'd7;
   localparam logic [3:0] PH_DATE_FIRST = 4'd8;
   localparam logic [3:0] PH_DATE_LAST  = 4'd13;

   localparam logic [2:0] HDR_LAST_POS  = 3'd6;
   localparam logic [2:0] SKIP_COMMAS   = 3'd7;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int DIGIT_COUNT = 12;
   localparam int STORE_DEPTH = DIGIT_COUNT - 1;

   localparam logic [6:0] YEAR_MIN   = 7'd23;
   localparam logic [4:0] MAX_OFFSET = 5'd23;
   localparam logic [4:0] TZ_RESET   = 5'd7;

   // Twelve captured characters: hh mm ss dd mm yy
   typedef struct packed {
      logic [DIGIT_COUNT-1:0][7:0] chars;
   } capture_type;

   // Header check at one position, either talker accepted
   function automatic logic header_hit(input logic [2:0] pos, input logic [7:0] c);
      logic hit;
      case (pos)
         3'd0:    hit = (c == "$");
         3'd1:    hit = (c == "G");
         3'd2:    hit = (c == "P") || (c == "N");
         3'd3:    hit = (c == "R");
         3'd4:    hit = (c == "M");
         3'd5:    hit = (c == "C");
         3'd6:    hit = (c == ",");
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Two ASCII digits to a value; only meaningful when both are numeric
   function automatic logic [6:0] pair_value(input logic [7:0] tens, input logic [7:0] ones);
      logic [7:0] sum;
      sum = 8'(tens[3:0]) * 8'd10 + 8'(ones[3:0]);
      return sum[6:0];
   endfunction

   // Month length, February lengthened in years divisible by four
   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [6:0] year);
      logic [4:0] n;
      case (month)
         4'd2:    n = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/nrmc_if.sv =====
// Channel interfaces for the RMC time and date parser: byte input, fix result
// and timezone register write. No dependencies.
interface nrmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       bad_fix;
   logic [4:0] hour_out;
   logic [5:0] minute_out;
   logic [5:0] second_out;
   logic [4:0] day_out;
   logic [3:0] month_out;
   logic [6:0] year_out;
   modport source (output valid, output bad_fix, output hour_out, output minute_out,
                   output second_out, output day_out, output month_out,
                   output year_out, input ready);
   modport sink   (input valid, input bad_fix, input hour_out, input minute_out,
                   input second_out, input day_out, input month_out,
                   input year_out, output ready);
endinterface

interface nrmc_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] tz_offset_hours;
   modport source (output valid, output tz_offset_hours, input ready);
   modport sink   (input valid, input tz_offset_hours, output ready);
endinterface

// ===== sv/nrmc_parser.sv =====
// Byte parser: header hunt, comma skip and digit capture into a sentence register.
// Depends on nrmc_pkg and nrmc_req_if.
module nrmc_parser (
   input  logic                  clock,
   input  logic                  reset,
   nrmc_req_if.sink              req_if,
   input  logic                  calc_ready,
   output logic                  cap_valid,
   output nrmc_pkg::capture_type cap_sentence
);
   import nrmc_pkg::*;

   logic [3:0]   phase_ff, phase_in;
   logic [2:0]   count_ff, count_in;
   logic [7:0]   store_ff [0:STORE_DEPTH-1];
   logic [3:0]   store_idx;
   logic         store_we;
   logic         cap_load;
   logic         cap_valid_ff, cap_valid_in;
   capture_type  cap_ff;
   logic         accept;

   // Take a byte whenever the capture register is free or draining
   assign req_if.ready = !cap_valid_ff || calc_ready;
   assign accept       = req_if.valid && req_if.ready;

   assign store_idx = (phase_ff <= PH_TIME_LAST) ? (phase_ff - 4'd1) : (phase_ff - 4'd2);

   // Advance the phase on each accepted byte
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      store_we = 1'b0;
      cap_load = 1'b0;
      if (accept) begin
         if (phase_ff == PH_HUNT) begin
            if (header_hit(count_ff, req_if.rx_byte)) begin
               if (count_ff == HDR_LAST_POS) begin
                  phase_in = PH_TIME_FIRST;
                  count_in = 3'd0;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end else begin
               count_in = 3'd0;
            end
         end else if (phase_ff == PH_SKIP) begin
            if (req_if.rx_byte == CHAR_COMMA) begin
               if (count_ff == SKIP_COMMAS) begin
                  phase_in = PH_DATE_FIRST;
                  count_in = 3'd0;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
         end else if (phase_ff inside {[PH_TIME_FIRST:PH_TIME_LAST],
                                       [PH_DATE_FIRST:PH_DATE_LAST]}) begin
            if (req_if.rx_byte == CHAR_COMMA) begin
               // Drop the sentence on a comma inside a digit run
               phase_in = PH_HUNT;
               count_in = 3'd0;
            end else if (phase_ff == PH_DATE_LAST) begin
               phase_in = PH_HUNT;
               count_in = 3'd0;
               cap_load = 1'b1;
            end else begin
               store_we = 1'b1;
               phase_in = phase_ff + 4'd1;
            end
         end else begin
            phase_in = PH_HUNT;
            count_in = 3'd0;
         end
      end
   end

   // Hold the capture until the calculation stage takes it
   always_comb begin
      if (cap_load) begin
         cap_valid_in = 1'b1;
      end else if (calc_ready) begin
         cap_valid_in = 1'b0;
      end else begin
         cap_valid_in = cap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= 3'd0;
         cap_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         cap_valid_ff <= cap_valid_in;
      end
   end

   // Digit store and sentence capture, last digit taken straight from the input
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= req_if.rx_byte;
      end
      if (cap_load) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            cap_ff.chars[i] <= store_ff[i];
         end
         cap_ff.chars[DIGIT_COUNT-1] <= req_if.rx_byte;
      end
   end

   assign cap_valid    = cap_valid_ff;
   assign cap_sentence = cap_ff;

endmodule

// ===== sv/nrmc_calc.sv =====
// Result stage: range check, timezone shift with calendar rollover, output register.
// Depends on nrmc_pkg and nrmc_rsp_if.
module nrmc_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cap_valid,
   input  nrmc_pkg::capture_type  cap_sentence,
   input  logic [4:0]             tz_offset,
   output logic                   calc_ready,
   nrmc_rsp_if.source             rsp_if
);
   import nrmc_pkg::*;

   logic       bad_char, bad_range, bad;
   logic [6:0] hour, minute, second, day, month, year;
   logic [4:0] offset;
   logic [5:0] hour_sum, hour_loc;
   logic       wrap, roll_day, roll_month;
   logic [5:0] day_next;
   logic [4:0] month_days;
   logic [4:0] day_res;
   logic [3:0] month_res;
   logic [6:0] year_res;
   logic       load;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       bad_ff;
   logic [4:0] hour_ff;
   logic [5:0] minute_ff, second_ff;
   logic [4:0] day_ff;
   logic [3:0] month_ff;
   logic [6:0] year_ff;

   // Check characters and decode the six pairs
   always_comb begin
      bad_char = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (!is_digit(cap_sentence.chars[i])) begin
            bad_char = 1'b1;
         end
      end
   end

   assign hour   = pair_value(cap_sentence.chars[0],  cap_sentence.chars[1]);
   assign minute = pair_value(cap_sentence.chars[2],  cap_sentence.chars[3]);
   assign second = pair_value(cap_sentence.chars[4],  cap_sentence.chars[5]);
   assign day    = pair_value(cap_sentence.chars[6],  cap_sentence.chars[7]);
   assign month  = pair_value(cap_sentence.chars[8],  cap_sentence.chars[9]);
   assign year   = pair_value(cap_sentence.chars[10], cap_sentence.chars[11]);

   assign bad_range = (hour > 7'd23) || (minute > 7'd59) || (second > 7'd59) ||
                      (day == 7'd0) || (day > 7'd31) || (month == 7'd0) ||
                      (month > 7'd12) || (year < YEAR_MIN);
   assign bad = bad_char || bad_range;

   // Shift the hour and roll the date forward
   assign offset     = (tz_offset > MAX_OFFSET) ? MAX_OFFSET : tz_offset;
   assign hour_sum   = 6'(hour[4:0]) + 6'(offset);
   assign wrap       = (hour_sum >= 6'd24);
   assign hour_loc   = wrap ? (hour_sum - 6'd24) : hour_sum;
   assign day_next   = 6'(day[4:0]) + 6'd1;
   assign month_days = days_in_month(month[3:0], year);
   assign roll_day   = wrap && (day_next > 6'(month_days));
   assign roll_month = roll_day && (month[3:0] == 4'd12);

   always_comb begin
      if (roll_day) begin
         day_res = 5'd1;
      end else if (wrap) begin
         day_res = day_next[4:0];
      end else begin
         day_res = day[4:0];
      end
      if (roll_month) begin
         month_res = 4'd1;
      end else if (roll_day) begin
         month_res = month[3:0] + 4'd1;
      end else begin
         month_res = month[3:0];
      end
      year_res = roll_month ? (year + 7'd1) : year;
   end

   // Output register with its own valid
   assign calc_ready = !rsp_valid_ff || rsp_if.ready;
   assign load       = cap_valid && calc_ready;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Zero every field of a bad fix
   always_ff @(posedge clock) begin
      if (load) begin
         bad_ff    <= bad;
         hour_ff   <= bad ? 5'd0 : hour_loc[4:0];
         minute_ff <= bad ? 6'd0 : minute[5:0];
         second_ff <= bad ? 6'd0 : second[5:0];
         day_ff    <= bad ? 5'd0 : day_res;
         month_ff  <= bad ? 4'd0 : month_res;
         year_ff   <= bad ? 7'd0 : year_res;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.bad_fix    = bad_ff;
   assign rsp_if.hour_out   = hour_ff;
   assign rsp_if.minute_out = minute_ff;
   assign rsp_if.second_out = second_ff;
   assign rsp_if.day_out    = day_ff;
   assign rsp_if.month_out  = month_ff;
   assign rsp_if.year_out   = year_ff;

endmodule

// ===== sv/nmea_rmc_time_date_parser.sv =====
// Channel  | Dir | Payload                                   | Handshake
// req_if   | in  | rx_byte                                   | valid/ready
// rsp_if   | out | bad_fix, hour/minute/second/day/month/year | valid/ready
// csr_if   | in  | tz_offset_hours                           | valid/ready, always ready
//
// One byte per cycle is taken while req_if.ready is high; the parser state is registered on acceptance.
// The last year digit loads a capture register; the checked, shifted fix is then loaded
// into the output register once the calculation stage is ready to take it.
// Synchronous reset clears the phase, the valids and sets the offset to 7 hours.
// A stalled result holds the output register; bytes keep flowing until the capture
// register is also full.
// Depends on nrmc_pkg, nrmc_if, nrmc_parser, nrmc_calc and assert_macros.svh.
`include "assert_macros.svh"

module nmea_rmc_time_date_parser (
   input logic        clock,
   input logic        reset,
   nrmc_req_if.sink   req_if,
   nrmc_rsp_if.source rsp_if,
   nrmc_csr_if.sink   csr_if
);
   import nrmc_pkg::*;

   logic         tz_write;
   logic [4:0]   tz_ff;
   logic         cap_valid;
   logic         calc_ready;
   capture_type  cap_sentence;

   // Timezone register, writable at any time
   assign csr_if.ready = 1'b1;
   assign tz_write     = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= TZ_RESET;
      end else if (tz_write) begin
         tz_ff <= csr_if.tz_offset_hours;
      end
   end

   nrmc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .calc_ready   (calc_ready),
      .cap_valid    (cap_valid),
      .cap_sentence (cap_sentence)
   );

   nrmc_calc u_calc (
      .clock        (clock),
      .reset        (reset),
      .cap_valid    (cap_valid),
      .cap_sentence (cap_sentence),
      .tz_offset    (tz_ff),
      .calc_ready   (calc_ready),
      .rsp_if       (rsp_if)
   );

   // Checks
   `NRMC_ASSERT_IMPLY(a_bad_fix_zeroed, rsp_if.valid && rsp_if.bad_fix,
      (rsp_if.hour_out == 5'd0) && (rsp_if.minute_out == 6'd0) &&
      (rsp_if.second_out == 6'd0) && (rsp_if.day_out == 5'd0) &&
      (rsp_if.month_out == 4'd0) && (rsp_if.year_out == 7'd0),
      "bad fix carries non-zero fields")
   `NRMC_ASSERT_IMPLY(a_good_fix_range, rsp_if.valid && !rsp_if.bad_fix,
      (rsp_if.hour_out < 5'd24) && (rsp_if.minute_out < 6'd60) &&
      (rsp_if.second_out < 6'd60) && (rsp_if.day_out != 5'd0) &&
      (rsp_if.month_out != 4'd0) && (rsp_if.month_out <= 4'd12) &&
      (rsp_if.year_out >= YEAR_MIN), "good fix out of range")
   `NRMC_ASSERT_NEXT(a_tz_written, tz_write,
      tz_ff == $past(csr_if.tz_offset_hours), "timezone write lost")

endmodule
